[hdl/tccs_pkg.sv]
// Package for the text console cursor and scroll engine.
// Holds shared constants, state and selector enums, item and result structs and attr_of.
// No dependencies.
package tccs_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [15:0] BLANK_CELL   = 16'h0020;
   localparam int          TAB_ADVANCE  = 4;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_BLANK,
      ST_WRITE,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ADDR_SCAN,
      ADDR_SCAN_STRIDE,
      ADDR_CURSOR,
      ADDR_READ
   } addr_sel_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] char_code;
      logic [2:0] colour_code;
      logic [4:0] read_row;
      logic [6:0] read_column;
   } item_type;

   typedef struct packed {
      logic        accepted;
      logic        cell_written;
      logic [4:0]  write_row;
      logic [6:0]  write_column;
      logic [15:0] stored_value;
      logic        scrolled;
      logic [15:0] read_value;
   } result_type;

   function automatic logic [15:0] attr_of(input logic [2:0] colour);
      logic [15:0] attr;
      case (colour)
         3'd0: attr = 16'h0F00;
         3'd1: attr = 16'h0700;
         3'd2: attr = 16'h0E00;
         3'd3: attr = 16'h0C00;
         3'd4: attr = 16'h0900;
         3'd5: attr = 16'h0A00;
         default: attr = 16'h0F00;
      endcase
      return attr;
   endfunction

endpackage

[hdl/tccs_cell_ram.sv]
// Single-port screen store with registered read data.
// Depends on nothing but its parameters.
module tccs_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [15:0]   wr_data,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tccs_addr_unit.sv]
// Shared address unit: one row multiply and one adder serve every store access.
// Uses tccs_pkg for the selector enum.
module tccs_addr_unit #(
   parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccs_pkg::DEF_ROWS,
   parameter int AW      = $clog2(COLUMNS * ROWS),
   parameter int RIW     = (ROWS > 2) ? $clog2(ROWS) : 1,
   parameter int CIW     = $clog2(COLUMNS)
) (
   input  tccs_pkg::addr_sel_type sel,
   input  logic [AW-1:0]          scan,
   input  logic [RIW-1:0]         cur_row,
   input  logic [CIW-1:0]         cur_col,
   input  logic [RIW-1:0]         rd_row,
   input  logic [CIW-1:0]         rd_col,
   output logic [AW-1:0]          addr
);

   localparam int SW = AW + 1;

   logic [RIW-1:0] row_m;
   logic [CIW-1:0] col_m;
   logic [SW-1:0]  base;
   logic [SW-1:0]  offset;
   logic [SW-1:0]  sum;

   always_comb begin
      row_m  = (sel == tccs_pkg::ADDR_READ) ? rd_row : cur_row;
      col_m  = (sel == tccs_pkg::ADDR_READ) ? rd_col : cur_col;
      base   = SW'(row_m) * SW'(COLUMNS);
      offset = SW'(col_m);
      case (sel)
         tccs_pkg::ADDR_SCAN: begin
            base   = SW'(scan);
            offset = '0;
         end
         tccs_pkg::ADDR_SCAN_STRIDE: begin
            base   = SW'(scan);
            offset = SW'(COLUMNS);
         end
         default: begin
         end
      endcase
      sum  = base + offset;
      addr = sum[AW-1:0];
   end

endmodule

[hdl/tccs_engine.sv]
// Sequencer for the console: store clear, cursor update, scroll copy and blank, cell write and read.
// Uses tccs_pkg, tccs_addr_unit and tccs_cell_ram.
module tccs_engine #(
   parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tccs_pkg::item_type   item,
   input  logic                 enabled,
   input  logic                 out_free,
   output logic                 idle,
   output logic                 done,
   output tccs_pkg::result_type result
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
   localparam int AW  = $clog2(CELL_COUNT);
   localparam int RIW = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int CIW = $clog2(COLUMNS);
   localparam int CW  = $clog2(COLUMNS + tccs_pkg::TAB_ADVANCE + 1);
   localparam int RW  = $clog2(ROWS + 1);

   tccs_pkg::state_type    state_ff, state_in;
   logic [AW-1:0]          scan_ff, scan_in;
   logic [CW-1:0]          cur_col_ff, cur_col_in;
   logic [RW-1:0]          cur_row_ff, cur_row_in;
   tccs_pkg::item_type     item_ff, item_in;
   logic                   skip_ff, skip_in;
   tccs_pkg::result_type   res_ff, res_in;

   tccs_pkg::addr_sel_type addr_sel;
   logic [AW-1:0]          ram_addr;
   logic                   ram_we;
   logic [15:0]            ram_wdata;
   logic [15:0]            ram_rdata;
   logic [15:0]            cell_value;

   logic [CW-1:0]          col_t;
   logic [RW-1:0]          row_t;
   logic                   skip_t;
   logic                   scroll_t;
   logic                   read_in_range;

   tccs_addr_unit #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW),
      .RIW     (RIW),
      .CIW     (CIW)
   ) u_addr (
      .sel     (addr_sel),
      .scan    (scan_ff),
      .cur_row (RIW'(cur_row_ff)),
      .cur_col (CIW'(cur_col_ff)),
      .rd_row  (RIW'(item_ff.read_row)),
      .rd_col  (CIW'(item_ff.read_column)),
      .addr    (ram_addr)
   );

   tccs_cell_ram #(
      .DEPTH   (CELL_COUNT),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tccs_pkg::ST_CLEAR;
         scan_ff    <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
      item_ff <= item_in;
      skip_ff <= skip_in;
      res_ff  <= res_in;
   end

   always_comb begin
      // Cursor update for a put: newline and tab first, then the wrap, then the scroll.
      skip_t = 1'b0;
      col_t  = cur_col_ff;
      row_t  = cur_row_ff;
      if (item_ff.char_code == tccs_pkg::CHAR_NEWLINE) begin
         row_t  = cur_row_ff + RW'(1);
         col_t  = '0;
         skip_t = 1'b1;
      end else if (item_ff.char_code == tccs_pkg::CHAR_TAB) begin
         col_t  = cur_col_ff + CW'(tccs_pkg::TAB_ADVANCE);
         skip_t = 1'b1;
      end
      if (col_t >= CW'(COLUMNS)) begin
         col_t = '0;
         row_t = row_t + RW'(1);
      end
      scroll_t = 1'b0;
      if (row_t >= RW'(ROWS)) begin
         row_t    = RW'(ROWS - 1);
         scroll_t = 1'b1;
      end
      read_in_range = (32'(item_ff.read_row) < ROWS) && (32'(item_ff.read_column) < COLUMNS);
      cell_value = tccs_pkg::attr_of(item_ff.colour_code) | {8'h00, item_ff.char_code};

      state_in   = state_ff;
      scan_in    = scan_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      item_in    = item_ff;
      skip_in    = skip_ff;
      res_in     = res_ff;
      addr_sel   = tccs_pkg::ADDR_SCAN;
      ram_we     = 1'b0;
      ram_wdata  = '0;
      done       = 1'b0;

      case (state_ff)
         tccs_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            if (scan_ff == AW'(CELL_COUNT - 1)) begin
               scan_in  = '0;
               state_in = tccs_pkg::ST_IDLE;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         tccs_pkg::ST_IDLE: begin
            if (start) begin
               item_in  = item;
               res_in   = '0;
               state_in = tccs_pkg::ST_DECIDE;
            end
         end
         tccs_pkg::ST_DECIDE: begin
            if (item_ff.opcode == tccs_pkg::OP_READ) begin
               state_in = read_in_range ? tccs_pkg::ST_READ : tccs_pkg::ST_DONE;
            end else if (!enabled) begin
               state_in = tccs_pkg::ST_DONE;
            end else begin
               res_in.accepted = 1'b1;
               res_in.scrolled = scroll_t;
               cur_col_in      = col_t;
               cur_row_in      = row_t;
               skip_in         = skip_t;
               scan_in         = '0;
               if (scroll_t) begin
                  state_in = tccs_pkg::ST_COPY_RD;
               end else if (!skip_t) begin
                  state_in = tccs_pkg::ST_WRITE;
               end else begin
                  state_in = tccs_pkg::ST_DONE;
               end
            end
         end
         tccs_pkg::ST_COPY_RD: begin
            addr_sel = tccs_pkg::ADDR_SCAN_STRIDE;
            state_in = tccs_pkg::ST_COPY_WR;
         end
         tccs_pkg::ST_COPY_WR: begin
            // The cell one row down arrived from the read in the previous cycle.
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            scan_in   = scan_ff + AW'(1);
            if (scan_ff == AW'(COPY_COUNT - 1)) begin
               state_in = tccs_pkg::ST_BLANK;
            end else begin
               state_in = tccs_pkg::ST_COPY_RD;
            end
         end
         tccs_pkg::ST_BLANK: begin
            ram_we    = 1'b1;
            ram_wdata = tccs_pkg::BLANK_CELL;
            if (scan_ff == AW'(CELL_COUNT - 1)) begin
               scan_in  = '0;
               state_in = skip_ff ? tccs_pkg::ST_DONE : tccs_pkg::ST_WRITE;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         tccs_pkg::ST_WRITE: begin
            addr_sel            = tccs_pkg::ADDR_CURSOR;
            ram_we              = 1'b1;
            ram_wdata           = cell_value;
            res_in.cell_written = 1'b1;
            res_in.write_row    = 5'(cur_row_ff);
            res_in.write_column = 7'(cur_col_ff);
            res_in.stored_value = cell_value;
            cur_col_in          = cur_col_ff + CW'(1);
            state_in            = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_READ: begin
            addr_sel = tccs_pkg::ADDR_READ;
            state_in = tccs_pkg::ST_READ_WAIT;
         end
         tccs_pkg::ST_READ_WAIT: begin
            res_in.read_value = ram_rdata;
            state_in          = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccs_pkg::ST_IDLE;
         end
      endcase
   end

   assign idle   = (state_ff == tccs_pkg::ST_IDLE);
   assign result = res_ff;

endmodule

[hdl/text_console_cursor_scroll.sv]
// Text console engine: cursor, wrap, scroll and a COLUMNS x ROWS screen store.
// Uses tccs_pkg and tccs_engine; the engine holds the store and address unit.
//
// One request is handled at a time by a small sequencer around a single-port
// screen store and one shared address adder. A read passes through decide,
// address, data and result states; a put without scroll passes through decide,
// write and result; newline, tab and disabled puts and out-of-range reads go
// from decide straight to result. A put that scrolls adds a copy of (ROWS-1)*COLUMNS
// cells (one read and one write per cell on the store port) and a blank of the
// COLUMNS cells of the bottom row. After reset the store is cleared in a pass
// over all COLUMNS*ROWS cells during which no request is taken; configuration
// writes are taken at any time. The result sits in an output register, so a new
// request can be taken while the previous result waits for its transfer.
module text_console_cursor_scroll #(
   parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
   parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_console_enabled,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [2:0]  req_colour_code,
   input  logic        req_end_of_text,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_column,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_cell_written,
   output logic [4:0]  rsp_write_row,
   output logic [6:0]  rsp_write_column,
   output logic [15:0] rsp_stored_value,
   output logic        rsp_scrolled,
   output logic [15:0] rsp_read_value
);

   logic                 enabled_ff, enabled_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tccs_pkg::result_type rsp_ff, rsp_in;

   tccs_pkg::item_type   item;
   tccs_pkg::result_type eng_result;
   logic                 eng_idle;
   logic                 eng_done;
   logic                 out_free;
   logic                 req_xfer;

   // The end-of-text marker does not affect the engine.
   logic                 end_of_text_seen;

   assign item.opcode      = req_opcode;
   assign item.char_code   = req_char_code;
   assign item.colour_code = req_colour_code;
   assign item.read_row    = req_read_row;
   assign item.read_column = req_read_column;
   assign end_of_text_seen = req_end_of_text;

   assign req_ready = eng_idle;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   tccs_engine #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .item     (item),
      .enabled  (enabled_ff),
      .out_free (out_free),
      .idle     (eng_idle),
      .done     (eng_done),
      .result   (eng_result)
   );

   always_comb begin
      enabled_in = enabled_ff;
      if (csr_valid && csr_ready) begin
         enabled_in = csr_console_enabled;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_cell_written = rsp_ff.cell_written;
   assign rsp_write_row    = rsp_ff.write_row;
   assign rsp_write_column = rsp_ff.write_column;
   assign rsp_stored_value = rsp_ff.stored_value;
   assign rsp_scrolled     = rsp_ff.scrolled;
   assign rsp_read_value   = rsp_ff.read_value;

   // A put never returns cell contents.
   a_put_no_read_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_read_value == 16'h0000))
      else $error("put result carries a read value");

   // Without a stored cell the write fields stay zero.
   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_cell_written) |->
      (rsp_stored_value == 16'h0000 && rsp_write_row == 5'd0 && rsp_write_column == 7'd0))
      else $error("write fields set without a stored cell");

   // Only an accepted put can scroll or store a cell.
   a_scroll_needs_put: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_scrolled || rsp_cell_written)) |-> rsp_accepted)
      else $error("scroll or cell write without an accepted put");

   // The sequencer is busy in the cycle after a request transfer.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !end_of_text_seen) || (req_xfer && end_of_text_seen) |=> !req_ready)
      else $error("request taken while the previous one is in progress");

endmodule
